// ----- hdl/stk_pkg.sv -----
// shared types and codes for the stack with two-stack sort
package stk_pkg;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SORT  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef struct packed {
    logic                main_we;
    logic                main_wsel_temp;
    logic                main_re;
    logic                temp_we;
    logic                temp_re;
    logic                temp_ahead;
    cnt_op_t             mc_op;
    cnt_op_t             tc_op;
    logic                held_load;
    logic                out_load;
    logic                out_val_main;
    logic [STATUS_W-1:0] out_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic main_empty;
    logic main_full;
    logic temp_empty;
    logic temp_one;
    logic less;
  } dp_stat_t;

endpackage

// ----- hdl/stack_with_two_stack_sort_top.sv -----
// top level of the bounded word stack with two-stack sort
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------
//  request | in_valid  | in_stall  | func, push_value
//  result  | out_valid | out_stall | value, empty, count, status
//
// push, pop, peek, clear and unused codes go from accept through the result state
// sort of n words pops each, moves larger scratch words to main (at most n(n-1)/2),
//   pushes the word to scratch, then drains scratch to main; one read port per ram
// one request is in work at a time; a new one is taken while a result waits
// reset clears counts, held word and control only; store contents stay undefined
// out_stall holds the result register and delays the next result and later requests
module stack_with_two_stack_sort_top #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [stk_pkg::FUNC_W-1:0]     func,
  input  logic signed [DATA_WIDTH-1:0]   push_value,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [DATA_WIDTH-1:0]   value,
  output logic                           empty,
  output logic [stk_pkg::COUNT_W-1:0]    count,
  output logic [stk_pkg::STATUS_W-1:0]   status
);
  import stk_pkg::*;

  ctrl_cmd_t dp_cmd;
  dp_stat_t  dp_stat;

  // sequencer: decodes each word and steps the sort
  stk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // stores, counters and the result register
  stk_dp #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .push_value (push_value),
    .value      (value),
    .empty      (empty),
    .count      (count),
    .status     (status)
  );

  // scratch stack is drained whenever a new request can be taken
  a_temp_drained: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> dp_stat.temp_empty)
    else $error("scratch stack not empty between requests");

  // a rejected push only happens on a full stack
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count == COUNT_W'(DEPTH) && !empty)
    else $error("full status with a count below depth");

  // an empty error returns zero on an empty stack
  a_empty_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> empty && value == '0)
    else $error("empty status with data or a nonzero count");

endmodule

// ----- hdl/stk_ram.sv -----
// generic single write port ram with registered read
module stk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/stk_dp.sv -----
// datapath: both stores, counts, held word and result register
module stk_dp #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  stk_pkg::ctrl_cmd_t               cmd,
  output stk_pkg::dp_stat_t                stat,
  input  logic signed [DATA_WIDTH-1:0]     push_value,
  output logic signed [DATA_WIDTH-1:0]     value,
  output logic                             empty,
  output logic [stk_pkg::COUNT_W-1:0]      count,
  output logic [stk_pkg::STATUS_W-1:0]     status
);
  import stk_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         main_count, main_count_next;
  logic [CW-1:0]         temp_count, temp_count_next;
  logic [CW-1:0]         mc_less1, tc_less1, tc_less2;
  logic [DATA_WIDTH-1:0] held_value;
  logic [DATA_WIDTH-1:0] main_rdata, temp_rdata, main_wdata;
  logic [AW-1:0]         temp_raddr;

  function automatic logic [CW-1:0] step_count(cnt_op_t op, logic [CW-1:0] c);
    logic [CW-1:0] r;
    case (op)
      CNT_INC: r = c + CW'(1);
      CNT_DEC: r = c - CW'(1);
      CNT_CLR: r = '0;
      default: r = c;
    endcase
    return r;
  endfunction

  assign mc_less1 = main_count - CW'(1);
  assign tc_less1 = temp_count - CW'(1);
  assign tc_less2 = temp_count - CW'(2);

  assign main_count_next = step_count(cmd.mc_op, main_count);
  assign temp_count_next = step_count(cmd.tc_op, temp_count);

  assign main_wdata = cmd.main_wsel_temp ? temp_rdata : push_value;
  assign temp_raddr = cmd.temp_ahead ? tc_less2[AW-1:0] : tc_less1[AW-1:0];

  stk_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_main_ram (
    .clk   (clk),
    .we    (cmd.main_we),
    .waddr (main_count[AW-1:0]),
    .wdata (main_wdata),
    .re    (cmd.main_re),
    .raddr (mc_less1[AW-1:0]),
    .rdata (main_rdata)
  );

  stk_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_temp_ram (
    .clk   (clk),
    .we    (cmd.temp_we),
    .waddr (temp_count[AW-1:0]),
    .wdata (held_value),
    .re    (cmd.temp_re),
    .raddr (temp_raddr),
    .rdata (temp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      main_count <= '0;
      temp_count <= '0;
      held_value <= '0;
    end else begin
      main_count <= main_count_next;
      temp_count <= temp_count_next;
      if (cmd.held_load) begin
        held_value <= main_rdata;
      end
    end
  end

  // result register, loaded once the counts reflect the finished request
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value  <= cmd.out_val_main ? main_rdata : '0;
      empty  <= (main_count == '0);
      count  <= COUNT_W'(main_count);
      status <= cmd.out_status;
    end
  end

  assign stat.main_empty = (main_count == '0);
  assign stat.main_full  = (main_count == CW'(DEPTH));
  assign stat.temp_empty = (temp_count == '0);
  assign stat.temp_one   = (temp_count == CW'(1));
  assign stat.less       = ($signed(held_value) < $signed(temp_rdata));

endmodule

// ----- hdl/stk_ctrl.sv -----
// controller: request decode and sort sequencer
module stk_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [stk_pkg::FUNC_W-1:0]   func,
  output logic                         out_valid,
  input  logic                         out_stall,
  input  stk_pkg::dp_stat_t            stat,
  output stk_pkg::ctrl_cmd_t           cmd
);
  import stk_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RESULT = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_HOLD   = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_PUSHT  = 3'd5;
  localparam logic [2:0] S_BACK   = 3'd6;
  localparam logic [2:0] S_BACKW  = 3'd7;

  logic [2:0]          state, state_next;
  logic [STATUS_W-1:0] status_r, status_r_next;
  logic                val_main, val_main_next;
  logic                out_valid_next;
  logic                accept;
  logic                slot_free;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next         = state;
    status_r_next      = status_r;
    val_main_next      = val_main;
    cmd.main_we        = 1'b0;
    cmd.main_wsel_temp = 1'b0;
    cmd.main_re        = 1'b0;
    cmd.temp_we        = 1'b0;
    cmd.temp_re        = 1'b0;
    cmd.temp_ahead     = 1'b0;
    cmd.mc_op          = CNT_HOLD;
    cmd.tc_op          = CNT_HOLD;
    cmd.held_load      = 1'b0;
    cmd.out_load       = 1'b0;
    cmd.out_val_main   = val_main;
    cmd.out_status     = status_r;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          status_r_next = ST_OK;
          val_main_next = 1'b0;
          state_next    = S_RESULT;
          unique case (func)
            FUNC_PUSH: begin
              if (stat.main_full) begin
                status_r_next = ST_FULL;
              end else begin
                cmd.main_we = 1'b1;
                cmd.mc_op   = CNT_INC;
              end
            end
            FUNC_POP: begin
              if (stat.main_empty) begin
                status_r_next = ST_EMPTY;
              end else begin
                cmd.main_re   = 1'b1;
                cmd.mc_op     = CNT_DEC;
                val_main_next = 1'b1;
              end
            end
            FUNC_PEEK: begin
              if (stat.main_empty) begin
                status_r_next = ST_EMPTY;
              end else begin
                cmd.main_re   = 1'b1;
                val_main_next = 1'b1;
              end
            end
            FUNC_CLEAR: begin
              cmd.mc_op = CNT_CLR;
            end
            FUNC_SORT: begin
              if (!stat.main_empty) begin
                state_next = S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_POP: begin
        cmd.main_re = 1'b1;
        cmd.mc_op   = CNT_DEC;
        state_next  = S_HOLD;
      end
      S_HOLD: begin
        cmd.held_load = 1'b1;
        if (stat.temp_empty) begin
          state_next = S_PUSHT;
        end else begin
          cmd.temp_re = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.less) begin
          cmd.main_we        = 1'b1;
          cmd.main_wsel_temp = 1'b1;
          cmd.mc_op          = CNT_INC;
          cmd.tc_op          = CNT_DEC;
          if (stat.temp_one) begin
            state_next = S_PUSHT;
          end else begin
            cmd.temp_re    = 1'b1;
            cmd.temp_ahead = 1'b1;
          end
        end else begin
          state_next = S_PUSHT;
        end
      end
      S_PUSHT: begin
        cmd.temp_we = 1'b1;
        cmd.tc_op   = CNT_INC;
        state_next  = stat.main_empty ? S_BACK : S_POP;
      end
      S_BACK: begin
        if (stat.temp_empty) begin
          state_next = S_RESULT;
        end else begin
          cmd.temp_re = 1'b1;
          cmd.tc_op   = CNT_DEC;
          state_next  = S_BACKW;
        end
      end
      S_BACKW: begin
        cmd.main_we        = 1'b1;
        cmd.main_wsel_temp = 1'b1;
        cmd.mc_op          = CNT_INC;
        state_next         = S_BACK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status_r  <= ST_OK;
      val_main  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      status_r  <= status_r_next;
      val_main  <= val_main_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
